// ----- rtl/core/cbor_tsv_pkg.sv -----
// Shared types and constants for the CBOR text string validator.
package cbor_tsv_pkg;

   // Input word: one raw byte and its end-of-buffer flag
   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_buffer;
   } req_word_type;

   // Result word: verdict for one string
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] text_length;
   } rsp_word_type;

   // Verdict from the decode stage to the output register
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } core_out_type;

   // Verdict codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_HEAD  = 3'd1;
   localparam logic [2:0] ST_BAD_LEN   = 3'd2;
   localparam logic [2:0] ST_TRUNCATED = 3'd3;
   localparam logic [2:0] ST_NUL_BYTE  = 3'd4;
   localparam logic [2:0] ST_BAD_UTF8  = 3'd5;

   // Decoder phase, one-hot
   typedef enum logic [3:0] {
      PH_HEAD    = 4'b0001,
      PH_EXTRA   = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_DROP    = 4'b1000
   } phase_type;

   localparam logic [15:0] MAX_TEXT_LEN_RESET = 16'd255;
   localparam logic [2:0]  MAJOR_TEXT         = 3'd3;
   localparam logic [4:0]  AI_ONE_BYTE        = 5'd24;
   localparam logic [4:0]  AI_LAST_VALID      = 5'd27;
   localparam logic [7:0]  CONT_LOW           = 8'h80;
   localparam logic [7:0]  CONT_HIGH          = 8'hbf;

endpackage

// ----- rtl/core/cbor_tsv_in_stage.sv -----
// Input register stage: holds one accepted word for the decoder.
module cbor_tsv_in_stage
   import cbor_tsv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  cbor_tsv_pkg::req_word_type req_word,
   input  logic                       advance,
   output logic                       step_en,
   output cbor_tsv_pkg::req_word_type step_word
);

   logic         valid_ff, valid_in;
   req_word_type word_ff;
   logic         accept;

   // Stall only when the held word cannot move on
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign step_en   = valid_ff && advance;
   assign step_word = word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

endmodule

// ----- rtl/core/cbor_tsv_core.sv -----
// Decoder: head, length, NUL and UTF-8 checks, one byte per step.
module cbor_tsv_core
   import cbor_tsv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_en,
   input  cbor_tsv_pkg::req_word_type step_word,
   input  logic [15:0]                max_text_len,
   output cbor_tsv_pkg::core_out_type core_out
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  extra_left_ff, extra_left_in;
   logic [1:0]  head_width_ff, head_width_in;
   logic [15:0] val16_ff, val16_in;       // low 16 bits of the length field
   logic        hi_nz_ff, hi_nz_in;       // any length bit above bit 15 set
   logic        upper_nz_ff, upper_nz_in; // upper half of the length field set
   logic [15:0] payload_left_ff, payload_left_in;
   logic [15:0] string_length_ff, string_length_in;
   logic [1:0]  cont_left_ff, cont_left_in;
   logic [7:0]  next_lo_ff, next_lo_in;
   logic [7:0]  next_hi_ff, next_hi_in;

   logic [7:0]  b;
   logic        eob;
   logic [2:0]  major;
   logic [4:0]  ai;
   logic [15:0] shift_val;
   logic        shift_hi_nz;
   logic [3:0]  half_bytes;
   logic        shift_upper_nz;
   logic [3:0]  left_after;
   logic        non_shortest;
   logic [15:0] len_val;
   logic        len_hi;
   logic        len_bad;
   logic [15:0] pl_dec;
   logic        rej;
   logic [2:0]  rej_code;
   logic        ok;

   assign b     = step_word.byte_in;
   assign eob   = step_word.end_of_buffer;
   assign major = b[7:5];
   assign ai    = b[4:0];

   // Shift one length byte into the tracked value
   assign shift_val      = {val16_ff[7:0], b};
   assign shift_hi_nz    = hi_nz_ff || (val16_ff[15:8] != 8'd0);
   assign half_bytes     = (4'd1 << head_width_ff) >> 1;
   assign shift_upper_nz = upper_nz_ff || ((b != 8'd0) && (extra_left_ff > half_bytes));
   assign left_after     = (extra_left_ff != 4'd0) ? extra_left_ff - 4'd1 : 4'd0;
   assign non_shortest   = (head_width_ff == 2'd0) ? (b < 8'd24) : !shift_upper_nz;

   // Length under test: inline value in head phase, shifted value otherwise
   assign len_val = (phase_ff == PH_HEAD) ? {11'd0, ai} : shift_val;
   assign len_hi  = (phase_ff == PH_HEAD) ? 1'b0 : shift_hi_nz;
   assign len_bad = len_hi || (len_val == 16'd0) || (len_val > max_text_len);

   assign pl_dec = (payload_left_ff != 16'd0) ? payload_left_ff - 16'd1 : 16'd0;

   // Next state and verdict for the word in the input register
   always_comb begin
      phase_in         = phase_ff;
      extra_left_in    = extra_left_ff;
      head_width_in    = head_width_ff;
      val16_in         = val16_ff;
      hi_nz_in         = hi_nz_ff;
      upper_nz_in      = upper_nz_ff;
      payload_left_in  = payload_left_ff;
      string_length_in = string_length_ff;
      cont_left_in     = cont_left_ff;
      next_lo_in       = next_lo_ff;
      next_hi_in       = next_hi_ff;
      rej              = 1'b0;
      rej_code         = ST_OK;
      ok               = 1'b0;

      unique case (phase_ff)
         PH_HEAD: begin
            if ((major != MAJOR_TEXT) || (ai > AI_LAST_VALID)) begin
               rej      = 1'b1;
               rej_code = ST_BAD_HEAD;
            end else if (ai < AI_ONE_BYTE) begin
               if (len_bad) begin
                  rej      = 1'b1;
                  rej_code = ST_BAD_LEN;
               end else begin
                  payload_left_in  = len_val;
                  string_length_in = len_val;
                  cont_left_in     = 2'd0;
                  next_lo_in       = CONT_LOW;
                  next_hi_in       = CONT_HIGH;
                  phase_in         = PH_PAYLOAD;
                  if (eob) begin
                     rej      = 1'b1;
                     rej_code = ST_TRUNCATED;
                  end
               end
            end else begin
               head_width_in = ai[1:0];
               extra_left_in = 4'd1 << ai[1:0];
               val16_in      = 16'd0;
               hi_nz_in      = 1'b0;
               upper_nz_in   = 1'b0;
               phase_in      = PH_EXTRA;
               if (eob) begin
                  rej      = 1'b1;
                  rej_code = ST_TRUNCATED;
               end
            end
         end

         PH_EXTRA: begin
            val16_in      = shift_val;
            hi_nz_in      = shift_hi_nz;
            upper_nz_in   = shift_upper_nz;
            extra_left_in = left_after;
            if (left_after == 4'd0) begin
               if (non_shortest) begin
                  rej      = 1'b1;
                  rej_code = ST_BAD_HEAD;
               end else if (len_bad) begin
                  rej      = 1'b1;
                  rej_code = ST_BAD_LEN;
               end else begin
                  payload_left_in  = len_val;
                  string_length_in = len_val;
                  cont_left_in     = 2'd0;
                  next_lo_in       = CONT_LOW;
                  next_hi_in       = CONT_HIGH;
                  phase_in         = PH_PAYLOAD;
                  if (eob) begin
                     rej      = 1'b1;
                     rej_code = ST_TRUNCATED;
                  end
               end
            end else if (eob) begin
               rej      = 1'b1;
               rej_code = ST_TRUNCATED;
            end
         end

         PH_PAYLOAD: begin
            payload_left_in = pl_dec;
            next_lo_in      = CONT_LOW;
            next_hi_in      = CONT_HIGH;
            if (b == 8'd0) begin
               rej      = 1'b1;
               rej_code = ST_NUL_BYTE;
            end else if (cont_left_ff != 2'd0) begin
               // continuation byte inside its allowed window
               if ((b < next_lo_ff) || (b > next_hi_ff)) begin
                  rej      = 1'b1;
                  rej_code = ST_BAD_UTF8;
               end else begin
                  cont_left_in = cont_left_ff - 2'd1;
               end
            end else begin
               // classify a lead byte
               priority if (b <= 8'h7f) begin
                  cont_left_in = 2'd0;
               end else if ((b >= 8'hc2) && (b <= 8'hdf)) begin
                  cont_left_in = 2'd1;
               end else if ((b >= 8'he0) && (b <= 8'hef)) begin
                  cont_left_in = 2'd2;
                  if (b == 8'he0) begin
                     next_lo_in = 8'ha0;
                  end else if (b == 8'hed) begin
                     next_hi_in = 8'h9f;
                  end
               end else if ((b >= 8'hf0) && (b <= 8'hf4)) begin
                  cont_left_in = 2'd3;
                  if (b == 8'hf0) begin
                     next_lo_in = 8'h90;
                  end else if (b == 8'hf4) begin
                     next_hi_in = 8'h8f;
                  end
               end else begin
                  rej      = 1'b1;
                  rej_code = ST_BAD_UTF8;
               end
            end
            if (!rej) begin
               if (pl_dec == 16'd0) begin
                  if (cont_left_in != 2'd0) begin
                     rej      = 1'b1;
                     rej_code = ST_BAD_UTF8;
                  end else begin
                     ok       = 1'b1;
                     phase_in = PH_HEAD;
                  end
               end else if (eob) begin
                  rej      = 1'b1;
                  rej_code = ST_TRUNCATED;
               end
            end
         end

         PH_DROP: begin
            if (eob) begin
               phase_in = PH_HEAD;
            end
         end

         default: begin
            phase_in = PH_HEAD;
         end
      endcase

      // Rejection: resync at the end flag
      if (rej) begin
         phase_in = eob ? PH_HEAD : PH_DROP;
      end
   end

   assign core_out.valid            = step_en && (rej || ok);
   assign core_out.word.status      = rej ? rej_code : ST_OK;
   assign core_out.word.text_length = ok ? string_length_ff : 16'd0;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEAD;
         extra_left_ff    <= 4'd0;
         head_width_ff    <= 2'd0;
         val16_ff         <= 16'd0;
         hi_nz_ff         <= 1'b0;
         upper_nz_ff      <= 1'b0;
         payload_left_ff  <= 16'd0;
         string_length_ff <= 16'd0;
         cont_left_ff     <= 2'd0;
         next_lo_ff       <= CONT_LOW;
         next_hi_ff       <= CONT_HIGH;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         extra_left_ff    <= extra_left_in;
         head_width_ff    <= head_width_in;
         val16_ff         <= val16_in;
         hi_nz_ff         <= hi_nz_in;
         upper_nz_ff      <= upper_nz_in;
         payload_left_ff  <= payload_left_in;
         string_length_ff <= string_length_in;
         cont_left_ff     <= cont_left_in;
         next_lo_ff       <= next_lo_in;
         next_hi_ff       <= next_hi_in;
      end
   end

endmodule

// ----- rtl/core/cbor_tsv_out_stage.sv -----
// Output register stage: holds one verdict until the consumer takes it.
module cbor_tsv_out_stage
   import cbor_tsv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cbor_tsv_pkg::core_out_type core_out,
   output logic                       advance,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cbor_tsv_pkg::rsp_word_type rsp_word
);

   logic         valid_ff;
   rsp_word_type word_ff;

   // Register is free when empty or being drained this cycle
   assign advance   = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= core_out.valid;
      end
   end

   // Load a new verdict only when the register is free
   always_ff @(posedge clock) begin
      if (advance && core_out.valid) begin
         word_ff <= core_out.word;
      end
   end

endmodule

// ----- rtl/core/cbor_text_string_validator.sv -----
// Top level of the CBOR text string validator.
//
//   port group  direction  handshake            word
//   req_        in         req_valid/req_stall  byte_in, end_of_buffer
//   rsp_        out        rsp_valid/rsp_stall  status, text_length
//   csr_        in         csr_wr_en            max_text_len (16 bits)
//
// One byte per cycle sustained while the output is not stalled. A byte is held in
// the input register, is decoded there, and its verdict, if any, is loaded into
// the output register when that register is free; rsp_valid rises with that load.
// Synchronous reset clears the decoder to head phase and max_text_len to 255.
// A stalled output register holds the decoder and raises req_stall in the same
// cycle once the input register is full.
module cbor_text_string_validator
   import cbor_tsv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  cbor_tsv_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cbor_tsv_pkg::rsp_word_type rsp_word,
   input  logic                       csr_wr_en,
   input  logic [15:0]                csr_wr_data
);

   logic         advance;
   logic         step_en;
   req_word_type step_word;
   core_out_type core_out;
   logic [15:0]  max_text_len_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_text_len_ff <= MAX_TEXT_LEN_RESET;
      end else if (csr_wr_en) begin
         max_text_len_ff <= csr_wr_data;
      end
   end

   cbor_tsv_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .advance   (advance),
      .step_en   (step_en),
      .step_word (step_word)
   );

   cbor_tsv_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .step_word    (step_word),
      .max_text_len (max_text_len_ff),
      .core_out     (core_out)
   );

   cbor_tsv_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .core_out  (core_out),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- rtl/core/cbor_tsv_checker.sv -----
// Port-level checks for the CBOR text string validator, with bind.
module cbor_tsv_checker
   import cbor_tsv_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input cbor_tsv_pkg::rsp_word_type rsp_word
);

   // No verdict right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("verdict present after reset");

   // Held verdict stays put while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled verdict changed");

   // Rejections carry no length
   a_reject_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != ST_OK) |-> rsp_word.text_length == 16'd0)
      else $error("rejected string reports a length");

   // Accepted strings are never empty
   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == ST_OK) |-> rsp_word.text_length != 16'd0)
      else $error("accepted string has zero length");

   // Status is one of the defined verdicts
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.status <= ST_BAD_UTF8))
      else $error("undefined status code");

endmodule

bind cbor_text_string_validator cbor_tsv_checker u_checker (.*);
